/* hw/rtl/aspa_provider_table_defines.svh */
// Assertion macros for the ASPA provider table.
// Included by the top level; it depends on nothing else.
`ifndef ASPA_PROVIDER_TABLE_DEFINES_SVH
`define ASPA_PROVIDER_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define APT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define APT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/aspt_pkg.sv */
// Types and codes shared by the ASPA provider table.
// No dependencies.
package aspt_pkg;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_SPARE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        RES_UNKNOWN   = 2'd0,
        RES_VALID     = 2'd1,
        RES_INVALID   = 2'd2,
        RES_UNDEFINED = 2'd3
    } t_res;

    typedef enum logic [2:0] {
        ST_STAGED   = 3'd0,
        ST_LOOKUP   = 3'd1,
        ST_INSERTED = 3'd2,
        ST_REPLACED = 3'd3,
        ST_DELETED  = 3'd4,
        ST_NOMATCH  = 3'd5,
        ST_FULL     = 3'd6,
        ST_TOOLONG  = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_WORDS
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] customer_asn;
        logic [15:0] afi;
        logic [4:0]  provider_count;
        logic [31:0] provider_asn;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [1:0] lookup_result;
        logic [2:0] status;
        logic [8:0] entry_count;
    } t_out_item;

endpackage

/* hw/rtl/aspa_provider_table.sv */
// Flow: a non-final run item, or the last item of a run that is too long, answers in the
// cycle after it is taken; every other item scans all ENTRIES slots of the entry RAM and
// then up to MAX_PROVIDERS provider words.
// Throughput: one item at a time; the next is taken once the result has left.
// Reset: synchronous, active low; afterwards a clearing pass over all ENTRIES slots marks
// every slot free, and no item is accepted until it ends.
// Depends on aspt_pkg, aspt_ram and aspa_provider_table_defines.svh.
`include "aspa_provider_table_defines.svh"

module aspa_provider_table
    import aspt_pkg::*;
#(
    parameter int ENTRIES       = 256,
    parameter int MAX_PROVIDERS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    // Slot address, word address, word count and entry total widths.
    localparam int AW = $clog2(ENTRIES);
    localparam int PW = (MAX_PROVIDERS > 1) ? $clog2(MAX_PROVIDERS) : 1;
    localparam int CW = $clog2(MAX_PROVIDERS + 1);
    localparam int TW = $clog2(ENTRIES + 1);

    // One entry record: the valid flag lives in the RAM, so the clearing
    // pass after reset is what makes every slot free.
    typedef struct packed {
        logic          valid;
        logic [31:0]   key;
        logic [15:0]   fam;
        logic [CW-1:0] cnt;
    } t_entry;

    t_state        r_state, n_state;
    logic [AW:0]   r_scan, n_scan;
    logic          r_rd_v, n_rd_v;
    logic [AW-1:0] r_rd_slot, n_rd_slot;
    logic          r_found, n_found;
    logic          r_free_ok, n_free_ok;
    logic [AW-1:0] r_hit_slot, n_hit_slot;
    logic [AW-1:0] r_free_slot, n_free_slot;
    logic [15:0]   r_hit_fam, n_hit_fam;
    logic [CW-1:0] r_hit_cnt, n_hit_cnt;
    t_op           r_op, n_op;
    logic [31:0]   r_key, n_key;
    logic [15:0]   r_afi, n_afi;
    logic [31:0]   r_prov, n_prov;
    logic [AW-1:0] r_slot, n_slot;
    logic [CW-1:0] r_widx, n_widx;
    logic          r_wv, n_wv;
    logic [PW-1:0] r_wpos, n_wpos;
    logic          r_wflag, n_wflag;
    t_status       r_ins_st, n_ins_st;
    logic [CW-1:0] r_stage_idx, n_stage_idx;
    logic          r_ovf, n_ovf;
    logic [TW-1:0] r_total, n_total;
    logic          r_out_v, n_out_v;
    t_res          r_res, n_res;
    t_status       r_status, n_status;

    logic          w_accept;
    logic          w_load_out;
    logic          w_ovf_new;
    logic [CW-1:0] w_wlim;
    t_entry        w_ent_rd;
    logic [TW+8:0] w_total_ext;

    logic             ent_we;
    logic [AW-1:0]    ent_waddr;
    t_entry           ent_wdata;
    logic [$bits(t_entry)-1:0] ent_rdata;
    logic             stg_we;
    logic [31:0]      stg_rdata;
    logic             prv_we;
    logic [31:0]      prv_rdata;

    // Entry store: key, family, count and valid flag of each slot.
    aspt_ram #(.WIDTH($bits(t_entry)), .DEPTH(ENTRIES)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (r_scan[AW-1:0]),
        .o_rdata (ent_rdata)
    );

    // Staging words of the run in progress.
    aspt_ram #(.WIDTH(32), .DEPTH(1 << PW)) u_stage_ram (
        .i_clk   (i_clk),
        .i_we    (stg_we),
        .i_waddr (r_stage_idx[PW-1:0]),
        .i_wdata (i_in.provider_asn),
        .i_raddr (r_widx[PW-1:0]),
        .o_rdata (stg_rdata)
    );

    // Provider lists, one row of 2**PW words per slot.
    aspt_ram #(.WIDTH(32), .DEPTH(ENTRIES << PW)) u_prov_ram (
        .i_clk   (i_clk),
        .i_we    (prv_we),
        .i_waddr ({r_slot, r_wpos}),
        .i_wdata (stg_rdata),
        .i_raddr ({r_slot, r_widx[PW-1:0]}),
        .o_rdata (prv_rdata)
    );

    assign w_ent_rd    = t_entry'(ent_rdata);
    assign o_in_stall  = !((r_state == S_IDLE) && !r_out_v);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_wlim      = (r_op == OP_LOOKUP) ? r_hit_cnt : r_stage_idx;
    assign w_total_ext = {9'd0, r_total};

    assign o_out_valid         = r_out_v;
    assign o_out.lookup_result = r_res;
    assign o_out.status        = r_status;
    assign o_out.entry_count   = w_total_ext[8:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_scan      <= '0;
            r_rd_v      <= 1'b0;
            r_found     <= 1'b0;
            r_free_ok   <= 1'b0;
            r_wv        <= 1'b0;
            r_wflag     <= 1'b0;
            r_stage_idx <= '0;
            r_ovf       <= 1'b0;
            r_total     <= '0;
            r_out_v     <= 1'b0;
            r_widx      <= '0;
        end else begin
            r_state     <= n_state;
            r_scan      <= n_scan;
            r_rd_v      <= n_rd_v;
            r_found     <= n_found;
            r_free_ok   <= n_free_ok;
            r_wv        <= n_wv;
            r_wflag     <= n_wflag;
            r_stage_idx <= n_stage_idx;
            r_ovf       <= n_ovf;
            r_total     <= n_total;
            r_out_v     <= n_out_v;
            r_widx      <= n_widx;
        end
        r_rd_slot   <= n_rd_slot;
        r_hit_slot  <= n_hit_slot;
        r_free_slot <= n_free_slot;
        r_hit_fam   <= n_hit_fam;
        r_hit_cnt   <= n_hit_cnt;
        r_op        <= n_op;
        r_key       <= n_key;
        r_afi       <= n_afi;
        r_prov      <= n_prov;
        r_slot      <= n_slot;
        r_wpos      <= n_wpos;
        r_ins_st    <= n_ins_st;
        r_res       <= n_res;
        r_status    <= n_status;
    end

    always_comb begin
        n_state     = r_state;
        n_scan      = r_scan;
        n_rd_v      = r_rd_v;
        n_rd_slot   = r_rd_slot;
        n_found     = r_found;
        n_free_ok   = r_free_ok;
        n_hit_slot  = r_hit_slot;
        n_free_slot = r_free_slot;
        n_hit_fam   = r_hit_fam;
        n_hit_cnt   = r_hit_cnt;
        n_op        = r_op;
        n_key       = r_key;
        n_afi       = r_afi;
        n_prov      = r_prov;
        n_slot      = r_slot;
        n_widx      = r_widx;
        n_wv        = r_wv;
        n_wpos      = r_wpos;
        n_wflag     = r_wflag;
        n_ins_st    = r_ins_st;
        n_stage_idx = r_stage_idx;
        n_ovf       = r_ovf;
        n_total     = r_total;
        n_out_v     = r_out_v;
        n_res       = r_res;
        n_status    = r_status;
        ent_we      = 1'b0;
        ent_waddr   = r_slot;
        ent_wdata   = '0;
        stg_we      = 1'b0;
        prv_we      = 1'b0;
        w_load_out  = 1'b0;
        w_ovf_new   = r_ovf;

        if (r_out_v && !i_out_stall) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ent_we    = 1'b1;
                ent_waddr = r_scan[AW-1:0];
                n_scan    = r_scan + 1'b1;
                if (r_scan == (AW+1)'(ENTRIES - 1)) begin
                    n_scan  = '0;
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (w_accept) begin
                    n_key     = i_in.customer_asn;
                    n_afi     = i_in.afi;
                    n_prov    = i_in.provider_asn;
                    n_scan    = '0;
                    n_rd_v    = 1'b0;
                    n_found   = 1'b0;
                    n_free_ok = 1'b0;
                    if (i_in.operation == OP_LOOKUP || i_in.operation == OP_SPARE) begin
                        n_op    = OP_LOOKUP;
                        n_state = S_SCAN;
                    end else begin
                        n_op = t_op'(i_in.operation);
                        // Stage the word, or mark the run as too long.
                        if (i_in.provider_count != 5'd0) begin
                            if (r_stage_idx < CW'(MAX_PROVIDERS)) begin
                                stg_we      = 1'b1;
                                n_stage_idx = r_stage_idx + 1'b1;
                            end else begin
                                w_ovf_new = 1'b1;
                            end
                        end
                        n_ovf = w_ovf_new;
                        if (!i_in.last) begin
                            w_load_out = 1'b1;
                            n_res      = RES_UNKNOWN;
                            n_status   = w_ovf_new ? ST_TOOLONG : ST_STAGED;
                        end else if (w_ovf_new) begin
                            w_load_out  = 1'b1;
                            n_res       = RES_UNKNOWN;
                            n_status    = ST_TOOLONG;
                            n_stage_idx = '0;
                            n_ovf       = 1'b0;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN: begin
                // Reads are issued one slot a cycle; the data of slot k
                // is judged in the cycle after its read.
                if (r_scan != (AW+1)'(ENTRIES)) begin
                    n_scan    = r_scan + 1'b1;
                    n_rd_v    = 1'b1;
                    n_rd_slot = r_scan[AW-1:0];
                end else begin
                    n_rd_v = 1'b0;
                end
                if (r_rd_v) begin
                    if (w_ent_rd.valid && (w_ent_rd.key == r_key) && !r_found) begin
                        n_found    = 1'b1;
                        n_hit_slot = r_rd_slot;
                        n_hit_fam  = w_ent_rd.fam;
                        n_hit_cnt  = w_ent_rd.cnt;
                    end
                    if (!w_ent_rd.valid && !r_free_ok) begin
                        n_free_ok   = 1'b1;
                        n_free_slot = r_rd_slot;
                    end
                end
                if (r_scan == (AW+1)'(ENTRIES) && !r_rd_v) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_widx  = '0;
                n_wv    = 1'b0;
                n_wflag = 1'b0;
                n_slot  = r_hit_slot;
                case (r_op)
                    OP_INSERT: begin
                        if (r_found || r_free_ok) begin
                            ent_we          = 1'b1;
                            ent_waddr       = r_found ? r_hit_slot : r_free_slot;
                            ent_wdata.valid = 1'b1;
                            ent_wdata.key   = r_key;
                            ent_wdata.fam   = r_afi;
                            ent_wdata.cnt   = r_stage_idx;
                            n_slot          = ent_waddr;
                            n_ins_st        = r_found ? ST_REPLACED : ST_INSERTED;
                            if (!r_found) begin
                                n_total = r_total + 1'b1;
                            end
                            if (r_stage_idx == '0) begin
                                w_load_out = 1'b1;
                                n_status   = n_ins_st;
                            end else begin
                                n_state = S_WORDS;
                            end
                        end else begin
                            w_load_out = 1'b1;
                            n_status   = ST_FULL;
                        end
                    end
                    OP_DELETE: begin
                        if (!r_found || r_hit_fam != r_afi || r_hit_cnt != r_stage_idx) begin
                            w_load_out = 1'b1;
                            n_status   = ST_NOMATCH;
                        end else if (r_stage_idx == '0) begin
                            ent_we     = 1'b1;
                            ent_waddr  = r_hit_slot;
                            n_total    = r_total - 1'b1;
                            w_load_out = 1'b1;
                            n_status   = ST_DELETED;
                        end else begin
                            n_state = S_WORDS;
                        end
                    end
                    default: begin
                        if (!r_found) begin
                            w_load_out = 1'b1;
                            n_status   = ST_LOOKUP;
                        end else if (r_hit_cnt == '0) begin
                            w_load_out = 1'b1;
                            n_status   = ST_LOOKUP;
                        end else begin
                            n_state = S_WORDS;
                        end
                    end
                endcase
                n_res = RES_UNKNOWN;
                if (r_op == OP_LOOKUP && r_found && r_hit_cnt == '0) begin
                    n_res = RES_UNDEFINED;
                end
            end

            S_WORDS: begin
                // Walk the provider row and the staging words side by side.
                if (r_widx != w_wlim) begin
                    n_widx = r_widx + 1'b1;
                    n_wv   = 1'b1;
                    n_wpos = r_widx[PW-1:0];
                end else begin
                    n_wv = 1'b0;
                end
                if (r_wv) begin
                    case (r_op)
                        OP_INSERT: prv_we = 1'b1;
                        OP_DELETE: begin
                            if (prv_rdata != stg_rdata) begin
                                n_wflag = 1'b1;
                            end
                        end
                        default: begin
                            if (prv_rdata == r_prov && r_hit_fam == r_afi) begin
                                n_wflag = 1'b1;
                            end
                        end
                    endcase
                end
                if (r_widx == w_wlim && !r_wv) begin
                    w_load_out = 1'b1;
                    n_res      = RES_UNKNOWN;
                    case (r_op)
                        OP_INSERT: n_status = r_ins_st;
                        OP_DELETE: begin
                            if (!r_wflag) begin
                                ent_we   = 1'b1;
                                n_total  = r_total - 1'b1;
                                n_status = ST_DELETED;
                            end else begin
                                n_status = ST_NOMATCH;
                            end
                        end
                        default: begin
                            n_status = ST_LOOKUP;
                            n_res    = r_wflag ? RES_VALID : RES_INVALID;
                        end
                    endcase
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished item other than a non-final run item or a lookup ends any run.
        if (w_load_out) begin
            n_out_v = 1'b1;
            if (r_state != S_IDLE) begin
                n_state = S_IDLE;
                if (r_op != OP_LOOKUP) begin
                    n_stage_idx = '0;
                    n_ovf       = 1'b0;
                end
            end
        end
    end

    // The result register is only loaded once the previous result has left.
    `APT_ASSERT_IMP(a_out_empty_on_load, i_clk, i_rst_n, w_load_out, !r_out_v, "result overwritten")
    // No item enters while slots are still being cleared.
    `APT_ASSERT_IMP(a_no_accept_clear, i_clk, i_rst_n, (r_state == S_CLEAR), o_in_stall, "accept during clear")
    // The staging count never passes the list capacity.
    `APT_ASSERT_IMP(a_stage_bound, i_clk, i_rst_n, 1'b1, (r_stage_idx <= CW'(MAX_PROVIDERS)), "staging overrun")
    // After an accepted item the block is busy or holds a result.
    `APT_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, o_in_stall, "accepted twice")

endmodule

/* hw/rtl/aspt_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module aspt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
